// ===== src/address_region_dispatch_table_defines.svh =====
// Assertion macros shared by the address region dispatch table RTL.
// No dependencies; included by the files that carry concurrent checks.
`ifndef ADDRESS_REGION_DISPATCH_TABLE_DEFINES_SVH
`define ADDRESS_REGION_DISPATCH_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ARDT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ARDT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/ardt_pkg.sv =====
// Package for the address region dispatch table: sizes, codes and shared types.
// No dependencies; compiled before every other file of the block.
`timescale 1ns / 1ps
`default_nettype none

package ardt_pkg;

	// Table geometry.
	localparam int ENTRIES    = 16;
	localparam int ADDR_WIDTH = 32;
	localparam int TAG_WIDTH  = 16;
	localparam int SLOT_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	// Fixed widths of the beat fields.
	localparam int OPCODE_W    = 2;
	localparam int FIELD_ADDR_W = 32;
	localparam int FIELD_LEN_W  = 32;
	localparam int FIELD_TAG_W  = 16;
	localparam int TICKET_W     = 4;
	localparam int STATUS_W     = 2;

	// Operation codes; the fourth code is unused and answers with a miss.
	localparam logic [OPCODE_W-1:0] OP_REGISTER   = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_UNREGISTER = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_DISPATCH   = 2'd2;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_MISS     = 2'd1,
		STAT_ZERO_LEN = 2'd2,
		STAT_FULL     = 2'd3
	} ardt_status_t;

	typedef logic [SLOT_W-1:0]     ardt_slot_t;
	typedef logic [ADDR_WIDTH-1:0] ardt_addr_t;
	typedef logic [TAG_WIDTH-1:0]  ardt_tag_t;

	// Port controls from the sequencer to the slot memory.
	typedef struct packed {
		logic       rd_en;
		ardt_slot_t rd_addr;
		logic       wr_en;
		ardt_slot_t wr_addr;
	} ardt_mem_ctl_t;

	typedef struct packed {
		ardt_status_t           status;
		logic [TICKET_W-1:0]    ticket_out;
		logic [FIELD_TAG_W-1:0] tag_out;
	} ardt_result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIND,
		ST_SCAN,
		ST_UNREG,
		ST_EMIT
	} ardt_state_t;

endpackage

`default_nettype wire

// ===== src/ardt_ifs.sv =====
// Valid/ready channel interfaces for the request and response beats.
// Depends on ardt_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ardt_req_if;
	import ardt_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [OPCODE_W-1:0]     opcode;
	logic [FIELD_ADDR_W-1:0] address;
	logic [FIELD_LEN_W-1:0]  length;
	logic [FIELD_TAG_W-1:0]  handler_tag;
	logic [TICKET_W-1:0]     ticket;

	modport source (output valid, output opcode, output address, output length,
		output handler_tag, output ticket, input ready);
	modport sink (input valid, input opcode, input address, input length,
		input handler_tag, input ticket, output ready);
endinterface

interface ardt_rsp_if;
	import ardt_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [STATUS_W-1:0]    status;
	logic [TICKET_W-1:0]    ticket_out;
	logic [FIELD_TAG_W-1:0] tag_out;

	modport source (output valid, output status, output ticket_out, output tag_out,
		input ready);
	modport sink (input valid, input status, input ticket_out, input tag_out,
		output ready);
endinterface

`default_nettype wire

// ===== src/address_region_dispatch_table.sv =====
// Top level of the address region dispatch table: sequencer, slot memory,
// shared range comparator and the response output register.
// Depends on ardt_pkg, ardt_ifs, ardt_slot_mem, ardt_range_cmp, ardt_ctrl.
//
//   Channel | Direction | Beat contents
//   req     | in        | opcode, address, length, handler_tag, ticket
//   rsp     | out       | status, ticket_out, tag_out
//
// One request beat is handled at a time; req.ready is high only while the
// sequencer is idle. A dispatch walks the slots through the one range
// comparator, one slot per cycle after a registered memory read. A register
// searches the valid bits one slot per cycle; an unregister reads its one
// slot, and every rejected request goes straight to its result. After reset
// all slots are empty; no clearing pass is needed. A stalled response is held
// in the output register while the next request is already being accepted.
`timescale 1ns / 1ps
`default_nettype none
`include "address_region_dispatch_table_defines.svh"

module address_region_dispatch_table (
	input logic       clk,
	input logic       arst_n,
	ardt_req_if.sink  req,
	ardt_rsp_if.source rsp
);
	import ardt_pkg::*;

	ardt_mem_ctl_t mem_ctl;
	ardt_addr_t    item_addr;
	ardt_addr_t    item_len;
	ardt_tag_t     item_tag;
	ardt_addr_t    rd_base;
	ardt_addr_t    rd_len;
	ardt_tag_t     rd_tag;
	logic          range_hit;
	logic          out_free;
	ardt_result_t  res;
	logic          res_vld;

	logic          out_vld_q;
	ardt_result_t  out_res_q;

	// The sequencer owns the request channel and all slot bookkeeping.
	ardt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.mem_ctl   (mem_ctl),
		.item_addr (item_addr),
		.item_len  (item_len),
		.item_tag  (item_tag),
		.rd_tag    (rd_tag),
		.range_hit (range_hit),
		.out_free  (out_free),
		.res       (res),
		.res_vld   (res_vld)
	);

	ardt_slot_mem u_slot_mem (
		.clk     (clk),
		.ctl     (mem_ctl),
		.wr_base (item_addr),
		.wr_len  (item_len),
		.wr_tag  (item_tag),
		.rd_base (rd_base),
		.rd_len  (rd_len),
		.rd_tag  (rd_tag)
	);

	// The fault address stays in the item register for the whole scan while
	// the memory presents one slot per cycle to the comparator.
	ardt_range_cmp u_range_cmp (
		.fault (item_addr),
		.base  (rd_base),
		.len   (rd_len),
		.hit   (range_hit)
	);

	// Output register: a new result may enter when the slot is empty or the
	// beat held in it is taken in the same cycle.
	assign out_free = !out_vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_vld && out_free) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_vld && out_free) out_res_q <= res;
	end

	assign rsp.valid      = out_vld_q;
	assign rsp.status     = out_res_q.status;
	assign rsp.ticket_out = out_res_q.ticket_out;
	assign rsp.tag_out    = out_res_q.tag_out;

	`ARDT_ASSERT_NXT(a_rsp_held_in_stall, clk, arst_n, out_vld_q && !rsp.ready, out_vld_q && $stable(out_res_q), "pending response lost or changed while stalled")

endmodule

`default_nettype wire

// ===== src/ardt_slot_mem.sv =====
// Slot storage: base, length and tag arrays with one write and one read port.
// Depends on ardt_pkg; read data is registered.
`timescale 1ns / 1ps
`default_nettype none

module ardt_slot_mem (
	input  logic                    clk,
	input  ardt_pkg::ardt_mem_ctl_t ctl,
	input  ardt_pkg::ardt_addr_t    wr_base,
	input  ardt_pkg::ardt_addr_t    wr_len,
	input  ardt_pkg::ardt_tag_t     wr_tag,
	output ardt_pkg::ardt_addr_t    rd_base,
	output ardt_pkg::ardt_addr_t    rd_len,
	output ardt_pkg::ardt_tag_t     rd_tag
);
	import ardt_pkg::*;

	ardt_addr_t base_mem [ENTRIES];
	ardt_addr_t len_mem  [ENTRIES];
	ardt_tag_t  tag_mem  [ENTRIES];

	ardt_addr_t rd_base_q;
	ardt_addr_t rd_len_q;
	ardt_tag_t  rd_tag_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			base_mem[ctl.wr_addr] <= wr_base;
			len_mem[ctl.wr_addr]  <= wr_len;
			tag_mem[ctl.wr_addr]  <= wr_tag;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_base_q <= base_mem[ctl.rd_addr];
			rd_len_q  <= len_mem[ctl.rd_addr];
			rd_tag_q  <= tag_mem[ctl.rd_addr];
		end
	end

	assign rd_base = rd_base_q;
	assign rd_len  = rd_len_q;
	assign rd_tag  = rd_tag_q;

endmodule

`default_nettype wire

// ===== src/ardt_range_cmp.sv =====
// Shared range comparator: is (fault - base) mod 2^ADDR_WIDTH below length.
// Depends on ardt_pkg for the address width.
`timescale 1ns / 1ps
`default_nettype none

module ardt_range_cmp (
	input  ardt_pkg::ardt_addr_t fault,
	input  ardt_pkg::ardt_addr_t base,
	input  ardt_pkg::ardt_addr_t len,
	output logic                 hit
);
	import ardt_pkg::*;

	ardt_addr_t offset;

	// Wrapping subtract folds the base and upper-bound checks into one compare.
	assign offset = fault - base;
	assign hit    = offset < len;

endmodule

`default_nettype wire

// ===== src/ardt_ctrl.sv =====
// Sequencer: decodes a request beat, walks the slots and builds the result.
// Depends on ardt_pkg, ardt_ifs and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "address_region_dispatch_table_defines.svh"

module ardt_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	ardt_req_if.sink                req,
	output ardt_pkg::ardt_mem_ctl_t mem_ctl,
	output ardt_pkg::ardt_addr_t    item_addr,
	output ardt_pkg::ardt_addr_t    item_len,
	output ardt_pkg::ardt_tag_t     item_tag,
	input  ardt_pkg::ardt_tag_t     rd_tag,
	input  logic                    range_hit,
	input  logic                    out_free,
	output ardt_pkg::ardt_result_t  res,
	output logic                    res_vld
);
	import ardt_pkg::*;

	localparam logic [SLOT_W:0] SCAN_END  = (SLOT_W + 1)'(ENTRIES);
	localparam ardt_slot_t      LAST_SLOT = SLOT_W'(ENTRIES - 1);

	ardt_state_t        state_q, state_d;
	logic [ENTRIES-1:0] valid_q;
	logic [SLOT_W:0]    scan_q;
	logic               cmp_pend_s1;
	ardt_slot_t         cmp_idx_s1;
	ardt_slot_t         unreg_idx_q;
	ardt_addr_t         addr_q;
	ardt_addr_t         len_q;
	ardt_tag_t          tag_q;
	ardt_result_t       res_q, res_d;
	logic               res_load;

	ardt_slot_t scan_idx;
	ardt_slot_t tk_idx;
	ardt_addr_t in_len;
	logic       accept;
	logic       tk_in_range;
	logic       unreg_ok;
	logic       free_here;
	logic       find_last;
	logic       scan_more;
	logic       scan_hit;
	logic       scan_miss;

	assign req.ready   = (state_q == ST_IDLE);
	assign accept      = req.valid && req.ready;
	assign scan_idx    = scan_q[SLOT_W-1:0];
	assign tk_idx      = SLOT_W'(req.ticket);
	assign in_len      = ADDR_WIDTH'(req.length);
	assign tk_in_range = 32'(req.ticket) < 32'(ENTRIES);
	assign unreg_ok    = tk_in_range && valid_q[tk_idx];
	assign free_here   = !valid_q[scan_idx];
	assign find_last   = (scan_idx == LAST_SLOT);
	assign scan_more   = (scan_q != SCAN_END);
	// Slots are compared in order, so the first hit is the lowest one.
	assign scan_hit    = cmp_pend_s1 && valid_q[cmp_idx_s1] && range_hit;
	assign scan_miss   = cmp_pend_s1 && !scan_hit && (cmp_idx_s1 == LAST_SLOT);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (req.opcode)
						OP_REGISTER:   state_d = (in_len == '0) ? ST_EMIT : ST_FIND;
						OP_UNREGISTER: state_d = unreg_ok ? ST_UNREG : ST_EMIT;
						OP_DISPATCH:   state_d = ST_SCAN;
						default:       state_d = ST_EMIT;
					endcase
				end
			end
			ST_FIND: begin
				if (free_here || find_last) state_d = ST_EMIT;
			end
			ST_SCAN: begin
				if (scan_hit || scan_miss) state_d = ST_EMIT;
			end
			ST_UNREG: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mem_ctl  = '0;
		res_load = 1'b0;
		res_d    = '{status: STAT_MISS, ticket_out: '0, tag_out: '0};
		res_vld  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					mem_ctl.rd_en   = (req.opcode == OP_UNREGISTER) && unreg_ok;
					mem_ctl.rd_addr = tk_idx;
					res_load        = 1'b1;
					if (req.opcode == OP_REGISTER) begin
						res_d.status = STAT_ZERO_LEN;
					end else if (req.opcode == OP_UNREGISTER) begin
						res_d.ticket_out = req.ticket;
					end
				end
			end
			ST_FIND: begin
				mem_ctl.wr_en   = free_here;
				mem_ctl.wr_addr = scan_idx;
				if (free_here) begin
					res_load         = 1'b1;
					res_d.status     = STAT_OK;
					res_d.ticket_out = TICKET_W'(scan_idx);
					res_d.tag_out    = FIELD_TAG_W'(tag_q);
				end else if (find_last) begin
					res_load     = 1'b1;
					res_d.status = STAT_FULL;
				end
			end
			ST_SCAN: begin
				mem_ctl.rd_en   = scan_more;
				mem_ctl.rd_addr = scan_idx;
				if (scan_hit) begin
					res_load         = 1'b1;
					res_d.status     = STAT_OK;
					res_d.ticket_out = TICKET_W'(cmp_idx_s1);
					res_d.tag_out    = FIELD_TAG_W'(rd_tag);
				end else if (scan_miss) begin
					res_load = 1'b1;
				end
			end
			ST_UNREG: begin
				res_load         = 1'b1;
				res_d.status     = STAT_OK;
				res_d.ticket_out = TICKET_W'(unreg_idx_q);
				res_d.tag_out    = FIELD_TAG_W'(rd_tag);
			end
			ST_EMIT: res_vld = 1'b1;
			default: res_vld = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			scan_q      <= '0;
			cmp_pend_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			cmp_pend_s1 <= (state_q == ST_SCAN) && scan_more;
			if (state_q == ST_FIND && free_here) valid_q[scan_idx] <= 1'b1;
			if (state_q == ST_UNREG) valid_q[unreg_idx_q] <= 1'b0;
			if (accept) begin
				scan_q <= '0;
			end else if (state_q == ST_FIND || (state_q == ST_SCAN && scan_more)) begin
				scan_q <= scan_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= scan_idx;
		if (accept) begin
			addr_q      <= ADDR_WIDTH'(req.address);
			len_q       <= in_len;
			tag_q       <= TAG_WIDTH'(req.handler_tag);
			unreg_idx_q <= tk_idx;
		end
		if (res_load) res_q <= res_d;
	end

	assign item_addr = addr_q;
	assign item_len  = len_q;
	assign item_tag  = tag_q;
	assign res       = res_q;

	`ARDT_ASSERT_NXT(a_register_sets_one, clk, arst_n, state_q == ST_FIND && free_here, $countones(valid_q) == $past($countones(valid_q)) + 1, "register did not occupy exactly one slot")
	`ARDT_ASSERT_NXT(a_unregister_frees_one, clk, arst_n, state_q == ST_UNREG, $countones(valid_q) + 1 == $past($countones(valid_q)), "unregister did not free exactly one slot")

endmodule

`default_nettype wire

// ===== verif/tb_address_region_dispatch_table.sv =====
// Testbench for address_region_dispatch_table: a directed then random beat stream with a
// table predictor and an in-order response scoreboard. Depends on ardt_pkg and ardt_ifs.
`timescale 1ns / 1ps

module tb_address_region_dispatch_table;
	import ardt_pkg::*;

	// The fourth opcode has no name in the package; the block answers it with a miss.
	localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

	// Number of random beats per idling phase, and the drain allowance at the end.
	localparam int BEATS_PER_PHASE = 500;
	localparam int DRAIN_CYCLES    = 50;

	// One request beat as it sits in the driver's queue.
	typedef struct {
		logic [OPCODE_W-1:0]     opcode;
		logic [FIELD_ADDR_W-1:0] address;
		logic [FIELD_LEN_W-1:0]  length;
		logic [FIELD_TAG_W-1:0]  handler_tag;
		logic [TICKET_W-1:0]     ticket;
	} table_req_t;

	logic clk;
	logic arst_n;

	ardt_req_if req_ch ();
	ardt_rsp_if rsp_ch ();

	address_region_dispatch_table uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Beats waiting to be driven, and the responses the table is expected to give,
	// oldest first.
	table_req_t   beats_pending[$];
	ardt_result_t results_due[$];

	// Intervals handed to the table by the generator, so that dispatch addresses can
	// be aimed at them. This list is only a hint: slots may have been freed since.
	ardt_addr_t known_base[$];
	ardt_addr_t known_len[$];

	// The predictor's own copy of the slot table.
	logic       tbl_live[ENTRIES];
	ardt_addr_t tbl_base[ENTRIES];
	ardt_addr_t tbl_len[ENTRIES];
	ardt_tag_t  tbl_tag[ENTRIES];

	// Idling percentages for the current phase.
	int unsigned send_idle_pct = 0;
	int unsigned rsp_stall_pct = 0;

	int unsigned mismatch_count = 0;
	int unsigned beats_sent     = 0;
	int unsigned rsp_checked    = 0;
	int unsigned n_hits         = 0;
	int unsigned n_misses       = 0;
	int unsigned n_full         = 0;
	int unsigned n_freed        = 0;

	// 100 MHz clock.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Works out the response to one accepted beat and updates the table copy.
	// Registration takes the lowest free slot; a zero length is refused before the
	// full check. Dispatch takes the lowest valid slot for which the wrapped
	// difference address - base is below the length.
	function automatic ardt_result_t predict_table_access(input table_req_t b);
		ardt_result_t r;
		ardt_addr_t   offset;
		ardt_slot_t   tk;
		r.status     = STAT_MISS;
		r.ticket_out = '0;
		r.tag_out    = '0;
		case (b.opcode)
			OP_REGISTER: begin
				if (ardt_addr_t'(b.length) == '0) begin
					r.status = STAT_ZERO_LEN;
				end else begin
					r.status = STAT_FULL;
					for (int i = 0; i < ENTRIES; i++) begin
						if (!tbl_live[i]) begin
							tbl_live[i]  = 1'b1;
							tbl_base[i]  = ardt_addr_t'(b.address);
							tbl_len[i]   = ardt_addr_t'(b.length);
							tbl_tag[i]   = ardt_tag_t'(b.handler_tag);
							r.status     = STAT_OK;
							r.ticket_out = TICKET_W'(i);
							r.tag_out    = FIELD_TAG_W'(tbl_tag[i]);
							break;
						end
					end
					if (r.status == STAT_FULL) begin
						n_full++;
					end
				end
			end
			OP_UNREGISTER: begin
				r.ticket_out = b.ticket;
				if (int'(b.ticket) < ENTRIES) begin
					tk = ardt_slot_t'(b.ticket);
					if (tbl_live[tk]) begin
						tbl_live[tk] = 1'b0;
						r.status     = STAT_OK;
						r.tag_out    = FIELD_TAG_W'(tbl_tag[tk]);
						n_freed++;
					end
				end
			end
			OP_DISPATCH: begin
				for (int i = 0; i < ENTRIES; i++) begin
					offset = ardt_addr_t'(b.address) - tbl_base[i];
					if (tbl_live[i] && offset < tbl_len[i]) begin
						r.status     = STAT_OK;
						r.ticket_out = TICKET_W'(i);
						r.tag_out    = FIELD_TAG_W'(tbl_tag[i]);
						break;
					end
				end
				if (r.status == STAT_OK) begin
					n_hits++;
				end else begin
					n_misses++;
				end
			end
			default: begin
				// The unused opcode leaves the table alone and reports a miss.
			end
		endcase
		return r;
	endfunction

	task automatic push_beat(input logic [OPCODE_W-1:0] op, input logic [FIELD_ADDR_W-1:0] addr,
		input logic [FIELD_LEN_W-1:0] len, input logic [FIELD_TAG_W-1:0] tag,
		input logic [TICKET_W-1:0] tk);
		table_req_t b;
		b.opcode      = op;
		b.address     = addr;
		b.length      = len;
		b.handler_tag = tag;
		b.ticket      = tk;
		beats_pending.push_back(b);
	endtask

	// One random beat. Fields that the chosen operation ignores still carry random
	// values, so every input bit toggles. Registrations lean toward short
	// intervals, and most dispatches are aimed inside or right at the edges of
	// an interval that was registered earlier, so hits are common. With more
	// registrations than frees, the table spends much of its time full.
	task automatic add_random_beat();
		table_req_t  b;
		int unsigned pick;
		int unsigned idx;
		b.opcode      = OP_UNUSED;
		b.address     = FIELD_ADDR_W'($urandom());
		b.length      = FIELD_LEN_W'($urandom());
		b.handler_tag = FIELD_TAG_W'($urandom());
		b.ticket      = TICKET_W'($urandom());
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			b.opcode = OP_REGISTER;
			case ($urandom_range(0, 19))
				0: b.length = '0;
				1: b.length = '1;
				2, 3: begin
					// Keep the fully random length.
				end
				default: b.length = FIELD_LEN_W'($urandom_range(1, 4096));
			endcase
			if (b.length != '0) begin
				known_base.push_back(ardt_addr_t'(b.address));
				known_len.push_back(ardt_addr_t'(b.length));
				if (known_base.size() > ENTRIES) begin
					void'(known_base.pop_front());
					void'(known_len.pop_front());
				end
			end
		end else if (pick < 62) begin
			b.opcode = OP_UNREGISTER;
		end else if (pick < 95) begin
			b.opcode = OP_DISPATCH;
			if (known_base.size() != 0 && $urandom_range(0, 3) != 0) begin
				idx = $urandom_range(0, known_base.size() - 1);
				case ($urandom_range(0, 7))
					0: b.address = known_base[idx] - 1;
					1: b.address = known_base[idx] + known_len[idx];
					2: b.address = known_base[idx] + known_len[idx] - 1;
					default: b.address = known_base[idx] +
						$urandom_range(0, known_len[idx] - 1);
				endcase
			end
		end
		beats_pending.push_back(b);
	endtask

	// Request driver: a new beat is presented only when the previous one has been
	// taken (or none is up), so valid never drops while a beat waits for ready.
	always @(posedge clk or negedge arst_n) begin
		table_req_t nxt;
		if (!arst_n) begin
			req_ch.valid       <= 1'b0;
			req_ch.opcode      <= '0;
			req_ch.address     <= '0;
			req_ch.length      <= '0;
			req_ch.handler_tag <= '0;
			req_ch.ticket      <= '0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (beats_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				nxt = beats_pending.pop_front();
				req_ch.valid       <= 1'b1;
				req_ch.opcode      <= nxt.opcode;
				req_ch.address     <= nxt.address;
				req_ch.length      <= nxt.length;
				req_ch.handler_tag <= nxt.handler_tag;
				req_ch.ticket      <= nxt.ticket;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Response back-pressure, redrawn every cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
		end
	end

	// Monitor: an accepted request beat is run through the predictor at once, and
	// an accepted response beat is checked against the oldest prediction. The
	// request side is handled first, although the block never answers in the cycle
	// in which it accepts.
	always @(posedge clk or negedge arst_n) begin
		table_req_t   seen;
		ardt_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				tbl_live[i] = 1'b0;
			end
			results_due.delete();
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				seen.opcode      = req_ch.opcode;
				seen.address     = req_ch.address;
				seen.length      = req_ch.length;
				seen.handler_tag = req_ch.handler_tag;
				seen.ticket      = req_ch.ticket;
				results_due.push_back(predict_table_access(seen));
				beats_sent++;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (results_due.size() == 0) begin
					$error("Response beat arrived with no request outstanding");
					mismatch_count++;
				end else begin
					want = results_due.pop_front();
					rsp_checked++;
					if (rsp_ch.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
						mismatch_count++;
					end
					if (rsp_ch.ticket_out !== want.ticket_out) begin
						$error("ticket_out: expected %0d, actual %0d", want.ticket_out,
							rsp_ch.ticket_out);
						mismatch_count++;
					end
					if (rsp_ch.tag_out !== want.tag_out) begin
						$error("tag_out: expected 0x%04h, actual 0x%04h", want.tag_out,
							rsp_ch.tag_out);
						mismatch_count++;
					end
				end
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		arst_n = 1'b0;

		// Directed opening. A zero length and the unused opcode come first, then an
		// interval that wraps past the top of the address space with checks on both
		// of its ends, then an interval covering almost everything that overlaps the
		// first, checked at the one address it leaves out. The table is then filled,
		// one more registration is refused as full, and a zero length on a full table
		// must still report zero length. Finally both early slots are freed.
		push_beat(OP_REGISTER, '1, '0, '1, '0);
		push_beat(OP_UNUSED, '1, '1, '1, '1);
		push_beat(OP_UNREGISTER, '0, '0, '0, 4'd15);
		push_beat(OP_REGISTER, 32'hFFFF_FFF0, 32'h0000_0020, 16'hFFFF, '0);
		push_beat(OP_DISPATCH, 32'h0000_000F, '0, '0, '0);
		push_beat(OP_DISPATCH, 32'h0000_0010, '0, '0, '0);
		push_beat(OP_REGISTER, 32'h0000_0000, 32'hFFFF_FFFF, 16'h0000, '0);
		push_beat(OP_DISPATCH, 32'hFFFF_FFFF, '0, '0, '0);
		for (int i = 2; i < ENTRIES; i++) begin
			push_beat(OP_REGISTER, 32'h1000_0000 + 32'(i) * 32'h100, 32'h80,
				FIELD_TAG_W'(16'h0A00 + i), '0);
		end
		push_beat(OP_REGISTER, 32'h2000_0000, 32'h10, 16'h1234, '0);
		push_beat(OP_REGISTER, 32'h2000_0000, '0, 16'h1234, '0);
		push_beat(OP_UNREGISTER, '0, '0, '0, 4'd1);
		push_beat(OP_UNREGISTER, '0, '0, '0, 4'd0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Four idling phases: none, sender only, receiver only, then both.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					rsp_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 52;
					rsp_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					rsp_stall_pct = 52;
				end
				default: begin
					send_idle_pct = 19;
					rsp_stall_pct = 19;
				end
			endcase
			repeat (BEATS_PER_PHASE) add_random_beat();
			wait (beats_pending.size() == 0);
		end

		// Let the last beat be taken and every response come back, then give the
		// block time to show any response it should not produce. The extra edge
		// lets the driver's update for the last popped beat settle first.
		@(posedge clk);
		wait (!req_ch.valid);
		wait (results_due.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d request beats and %0d checked responses.",
			beats_sent, rsp_checked);
		$display("Dispatch hits %0d, dispatch misses %0d, full-table refusals %0d, frees %0d.",
			n_hits, n_misses, n_full, n_freed);
		if (mismatch_count == 0 && results_due.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Watchdog: a correct run needs well under a tenth of this.
	initial begin
		#5_000_000;
		$display("Timeout with %0d responses still outstanding.", results_due.size());
		$display("Mismatches found");
		$finish;
	end

endmodule
